### rtl/dcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcv_pkg: shared constants, types and tables of the civil date converter
// Field widths, calendar constants, fixed-point reciprocals for the constant
// divisions, the lane result type and the month tables.
// ----------------------------------------------------------------------------
package dcv_pkg;

  // field widths
  localparam int YEAR_W      = 14;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int COUNT_IN_W  = 24;
  localparam int COUNT_OUT_W = 23;
  localparam int WDAY_W      = 3;
  localparam int Z_W         = 22;   // days since 0000-03-01
  localparam int DOE_W       = 18;   // day of era
  localparam int DOY_W       = 9;    // day of march-based year
  localparam int YOE_W       = 9;    // year of era
  localparam int ERA_W       = 5;
  localparam int MP_W        = 4;    // march-based month index

  // pipeline depth of each lane and the compute part of the date lane
  localparam int LANE_LAT = 9;
  localparam int FWD_CALC = 3;

  // calendar constants
  localparam logic signed [COUNT_IN_W-1:0] MIN_COUNT   = -24'sd719162;
  localparam logic signed [COUNT_IN_W-1:0] MAX_COUNT   = 24'sd2932896;
  localparam logic signed [COUNT_IN_W-1:0] EPOCH_SHIFT = 24'sd719468;
  localparam logic [DOE_W-1:0]  ERA_DAYS  = 18'd146097;
  localparam logic [DOE_W-1:0]  ERA_LAST  = 18'd146096;
  localparam logic [YEAR_W-1:0] YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
  localparam logic [Z_W-1:0]    WDAY_BIAS = 22'd2;    // 0001-01-01 lands on zero
  localparam logic [MP_W-1:0]   MP_JAN    = 4'd10;    // first index of jan/feb

  // reciprocals: q = (x * RCP) >> SH, exact over the operand width used
  localparam int SH_ERA  = 40;
  localparam logic [22:0] RCP_ERA  = 23'(((64'd1 << SH_ERA) + 64'd146097 - 64'd1) / 64'd146097);
  localparam int SH_4Y   = 29;
  localparam logic [18:0] RCP_4Y   = 19'(((64'd1 << SH_4Y) + 64'd1460 - 64'd1) / 64'd1460);
  localparam int SH_CENT = 34;
  localparam logic [18:0] RCP_CENT = 19'(((64'd1 << SH_CENT) + 64'd36524 - 64'd1) / 64'd36524);
  localparam int SH_YEAR = 27;
  localparam logic [18:0] RCP_YEAR = 19'(((64'd1 << SH_YEAR) + 64'd365 - 64'd1) / 64'd365);
  localparam int SH_C9   = 16;
  localparam logic [9:0]  RCP_C9   = 10'(((64'd1 << SH_C9) + 64'd100 - 64'd1) / 64'd100);
  localparam int SH_MON  = 19;
  localparam logic [11:0] RCP_MON  = 12'(((64'd1 << SH_MON) + 64'd153 - 64'd1) / 64'd153);
  localparam int SH_C14  = 21;
  localparam logic [14:0] RCP_C14  = 15'(((64'd1 << SH_C14) + 64'd100 - 64'd1) / 64'd100);
  localparam int SH_WK   = 25;
  localparam logic [22:0] RCP_WK   = 23'(((64'd1 << SH_WK) + 64'd7 - 64'd1) / 64'd7);

  // what each lane hands to the output stage
  typedef struct packed {
    logic               valid;
    logic               ok;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [Z_W-1:0]     z;
  } lane_t;

  // first day of each month in a march-based year
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // days in a month, zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/dcv_fwd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcv_fwd: date to day number lane
// Checks the date fields, forms the day number counted from 0000-03-01 in
// three stages and delays it to the depth of the day count lane.
// ----------------------------------------------------------------------------
module dcv_fwd (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [dcv_pkg::YEAR_W-1:0]  year,
  input  logic [dcv_pkg::MONTH_W-1:0] month,
  input  logic [dcv_pkg::DAY_W-1:0]   day,
  output dcv_pkg::lane_t              lane
);
  import dcv_pkg::*;

  localparam int PAD = LANE_LAT - FWD_CALC;

  // stage 1: range checks, march-based year and month, century product
  logic              jan_feb;
  logic              s1_ok_nxt;
  logic [YEAR_W-1:0] s1_yy_nxt;
  logic [MP_W-1:0]   s1_mp_nxt;
  logic [28:0]       s1_p_nxt;

  logic               s1_vld_r, s1_ok_r;
  logic [YEAR_W-1:0]  s1_year_r, s1_yy_r;
  logic [MONTH_W-1:0] s1_month_r;
  logic [DAY_W-1:0]   s1_day_r;
  logic [MP_W-1:0]    s1_mp_r;
  logic [28:0]        s1_p_r;

  assign jan_feb   = (month < 4'd3);
  assign s1_ok_nxt = (year != '0) && (year <= YEAR_MAX) && (month != '0) &&
                     (month <= MONTH_MAX) && (day != '0);
  assign s1_yy_nxt = year - 14'(jan_feb);
  assign s1_mp_nxt = jan_feb ? month + 4'd9 : month - 4'd3;
  assign s1_p_nxt  = {15'd0, s1_yy_nxt} * {14'd0, RCP_C14};

  // stage 2: days of whole years, day within the year
  logic [7:0]       c100;
  logic [5:0]       c400;
  logic [Z_W-1:0]   s2_s_nxt;
  logic [DOY_W-1:0] s2_doy_nxt;

  logic               s2_vld_r, s2_ok_r;
  logic [YEAR_W-1:0]  s2_year_r;
  logic [MONTH_W-1:0] s2_month_r;
  logic [DAY_W-1:0]   s2_day_r;
  logic [Z_W-1:0]     s2_s_r;
  logic [DOY_W-1:0]   s2_doy_r;

  assign c100       = s1_p_r[28:21];
  assign c400       = c100[7:2];
  assign s2_s_nxt   = 22'(24'(s1_yy_r) * 24'd365 + 24'(s1_yy_r[13:2]) - 24'(c100) + 24'(c400));
  assign s2_doy_nxt = month_start(s1_mp_r) + 9'(s1_day_r) - 9'd1;

  // stage 3: day number, then a delay line
  lane_t s3_nxt;
  lane_t s3_r;
  lane_t pad_r [PAD];

  always_comb begin
    s3_nxt.valid = s2_vld_r;
    s3_nxt.ok    = s2_ok_r;
    s3_nxt.year  = s2_year_r;
    s3_nxt.month = s2_month_r;
    s3_nxt.day   = s2_day_r;
    s3_nxt.z     = s2_s_r + 22'(s2_doy_r);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_r.valid <= 1'b0;
      for (int i = 0; i < PAD; i++) pad_r[i].valid <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_r     <= s3_nxt;
      pad_r[0] <= s3_r;
      for (int i = 1; i < PAD; i++) pad_r[i] <= pad_r[i-1];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    s1_ok_r    <= s1_ok_nxt;
    s1_year_r  <= year;
    s1_month_r <= month;
    s1_day_r   <= day;
    s1_yy_r    <= s1_yy_nxt;
    s1_mp_r    <= s1_mp_nxt;
    s1_p_r     <= s1_p_nxt;
    s2_ok_r    <= s1_ok_r;
    s2_year_r  <= s1_year_r;
    s2_month_r <= s1_month_r;
    s2_day_r   <= s1_day_r;
    s2_s_r     <= s2_s_nxt;
    s2_doy_r   <= s2_doy_nxt;
  end

  assign lane = pad_r[PAD-1];

endmodule

### rtl/dcv_inv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcv_inv: day count to date lane
// Range check and era split, then year of era, day of year and month over
// nine stages, each constant division done by a reciprocal product.
// ----------------------------------------------------------------------------
module dcv_inv (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_vld,
  input  logic signed [dcv_pkg::COUNT_IN_W-1:0] count,
  output dcv_pkg::lane_t                        lane
);
  import dcv_pkg::*;

  // per-stage carried values: valid, range flag, day number, era
  logic [8:1]       vld_r;
  logic [8:1]       ok_r;
  logic [Z_W-1:0]   z_r   [1:8];
  logic [ERA_W-1:0] era_r [2:8];

  // stage 1: range check, shift to 0000-03-01, era product
  logic signed [COUNT_IN_W-1:0] zs;
  logic                         ok_nxt;
  logic [Z_W-1:0]               z_nxt;
  logic [44:0]                  pe_nxt;
  logic [44:0]                  pe_r;

  assign ok_nxt = (count >= MIN_COUNT) && (count <= MAX_COUNT);
  assign zs     = count + EPOCH_SHIFT;
  assign z_nxt  = zs[Z_W-1:0];
  assign pe_nxt = {23'd0, z_nxt} * {22'd0, RCP_ERA};

  // stage 2: era and day of era
  logic [ERA_W-1:0] era_nxt;
  logic [22:0]      eoff;
  logic [DOE_W-1:0] doe_nxt;
  logic [DOE_W-1:0] doe_r [2:6];

  assign era_nxt = pe_r[44:40];
  assign eoff    = {18'd0, era_nxt} * {5'd0, ERA_DAYS};
  assign doe_nxt = 18'({1'b0, z_r[1]} - eoff);

  // stage 3: four-year and century products
  logic [36:0] p4y_nxt, pcent_nxt;
  logic [36:0] p4y_r, pcent_r;

  assign p4y_nxt   = {19'd0, doe_r[2]} * {18'd0, RCP_4Y};
  assign pcent_nxt = {19'd0, doe_r[2]} * {18'd0, RCP_CENT};

  // stage 4: day of era with leap days taken out
  logic [DOE_W-1:0] t_nxt, t_r;

  assign t_nxt = doe_r[3] - 18'(p4y_r[36:29]) + 18'(pcent_r[36:34]) -
                 18'(doe_r[3] == ERA_LAST);

  // stage 5: year product
  logic [36:0] py_nxt, py_r;

  assign py_nxt = {19'd0, t_r} * {18'd0, RCP_YEAR};

  // stage 6: year of era and its day offset terms
  logic [YOE_W-1:0] yoe_nxt;
  logic [17:0]      r365_nxt, r365_r;
  logic [18:0]      pc_nxt, pc_r;
  logic [YOE_W-1:0] yoe_r [6:8];

  assign yoe_nxt  = py_r[35:27];
  assign r365_nxt = {9'd0, yoe_nxt} * 18'd365;
  assign pc_nxt   = {10'd0, yoe_nxt} * {9'd0, RCP_C9};

  // stage 7: day of year
  logic [17:0]      base;
  logic [17:0]      doy_full;
  logic [DOY_W-1:0] doy_nxt;
  logic [DOY_W-1:0] doy_r [7:8];

  assign base     = r365_r + 18'(yoe_r[6][8:2]) - 18'(pc_r[18:16]);
  assign doy_full = doe_r[6] - base;
  assign doy_nxt  = doy_full[DOY_W-1:0];

  // stage 8: month product
  logic [10:0] mx;
  logic [22:0] pm_nxt, pm_r;

  assign mx     = {2'd0, doy_r[7]} * 11'd5 + 11'd2;
  assign pm_nxt = {12'd0, mx} * {11'd0, RCP_MON};

  // stage 9: civil year, month and day
  logic [MP_W-1:0]  mp;
  logic [DOY_W-1:0] dfull;
  lane_t            lane_nxt;
  lane_t            lane_r;

  assign mp    = pm_r[22:19];
  assign dfull = doy_r[8] - month_start(mp) + 9'd1;

  always_comb begin
    lane_nxt.valid = vld_r[8];
    lane_nxt.ok    = ok_r[8];
    lane_nxt.year  = {9'd0, era_r[8]} * 14'd400 + {5'd0, yoe_r[8]} + 14'(mp >= MP_JAN);
    lane_nxt.month = (mp < MP_JAN) ? mp + 4'd3 : mp - 4'd9;
    lane_nxt.day   = dfull[DAY_W-1:0];
    lane_nxt.z     = z_r[8];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      lane_r.valid <= 1'b0;
    end else begin
      vld_r  <= {vld_r[7:1], in_vld};
      lane_r <= lane_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    ok_r     <= {ok_r[7:1], ok_nxt};
    z_r[1]   <= z_nxt;
    for (int i = 2; i <= 8; i++) z_r[i] <= z_r[i-1];
    pe_r     <= pe_nxt;
    era_r[2] <= era_nxt;
    for (int i = 3; i <= 8; i++) era_r[i] <= era_r[i-1];
    doe_r[2] <= doe_nxt;
    for (int i = 3; i <= 6; i++) doe_r[i] <= doe_r[i-1];
    p4y_r    <= p4y_nxt;
    pcent_r  <= pcent_nxt;
    t_r      <= t_nxt;
    py_r     <= py_nxt;
    yoe_r[6] <= yoe_nxt;
    yoe_r[7] <= yoe_r[6];
    yoe_r[8] <= yoe_r[7];
    r365_r   <= r365_nxt;
    pc_r     <= pc_nxt;
    doy_r[7] <= doy_nxt;
    doy_r[8] <= doy_r[7];
    pm_r     <= pm_nxt;
  end

  assign lane = lane_r;

endmodule

### rtl/dcv_tail.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcv_tail: shared result stages
// Picks the lane that holds the beat, works out weekday, leap flag, month
// length and the final date check, and drives the registered result ports.
// ----------------------------------------------------------------------------
module dcv_tail (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dcv_pkg::lane_t                         fwd,
  input  dcv_pkg::lane_t                         inv,
  output logic                                   out_valid,
  output logic                                   out_ok,
  output logic signed [dcv_pkg::COUNT_OUT_W-1:0] out_count_out,
  output logic [dcv_pkg::YEAR_W-1:0]             out_year_out,
  output logic [dcv_pkg::MONTH_W-1:0]            out_month_out,
  output logic [dcv_pkg::DAY_W-1:0]              out_day_out,
  output logic [dcv_pkg::WDAY_W-1:0]             out_weekday,
  output logic                                   out_leap,
  output logic [dcv_pkg::DAY_W-1:0]              out_month_length
);
  import dcv_pkg::*;

  // stage 1: lane select, weekday and century products
  lane_t          sel;
  logic [Z_W-1:0] wx_nxt;
  logic [44:0]    pw_nxt;
  logic [28:0]    py_nxt;

  logic               t1_vld_r, t1_mode_r, t1_ok_r;
  logic [YEAR_W-1:0]  t1_year_r;
  logic [MONTH_W-1:0] t1_month_r;
  logic [DAY_W-1:0]   t1_day_r;
  logic [Z_W-1:0]     t1_z_r, t1_wx_r;
  logic [44:0]        t1_pw_r;
  logic [28:0]        t1_py_r;

  assign sel    = inv.valid ? inv : fwd;
  assign wx_nxt = sel.z + WDAY_BIAS;
  assign pw_nxt = {23'd0, wx_nxt} * {22'd0, RCP_WK};
  assign py_nxt = {15'd0, sel.year} * {14'd0, RCP_C14};

  // stage 2: weekday remainder, leap rule, month length, final check
  logic [19:0]             wq;
  logic [22:0]             w7;
  logic [22:0]             wrem;
  logic [7:0]              q100;
  logic [YEAR_W-1:0]       r100;
  logic                    leap;
  logic [DAY_W-1:0]        mlen;
  logic                    good;
  logic [COUNT_OUT_W-1:0]  cnt;

  assign wq   = t1_pw_r[44:25];
  assign w7   = {3'd0, wq} * 23'd7;
  assign wrem = {1'b0, t1_wx_r} - w7;
  assign q100 = t1_py_r[28:21];
  assign r100 = t1_year_r - {6'd0, q100} * 14'd100;
  assign leap = (t1_year_r[1:0] == 2'd0) && ((r100 != '0) || (q100[1:0] == 2'd0));
  assign mlen = month_len(t1_month_r, leap);
  assign good = t1_ok_r && (t1_mode_r || (t1_day_r <= mlen));
  assign cnt  = {1'b0, t1_z_r} - 23'(EPOCH_SHIFT);

  logic                          out_valid_r, out_ok_r, out_leap_r;
  logic signed [COUNT_OUT_W-1:0] out_count_r;
  logic [YEAR_W-1:0]             out_year_r;
  logic [MONTH_W-1:0]            out_month_r;
  logic [DAY_W-1:0]              out_day_r, out_mlen_r;
  logic [WDAY_W-1:0]             out_wday_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      t1_vld_r    <= fwd.valid | inv.valid;
      out_valid_r <= t1_vld_r;
    end
  end

  // stage payload and result beat, all zero on a bad input
  always_ff @(posedge clk) begin
    t1_mode_r  <= inv.valid;
    t1_ok_r    <= sel.ok;
    t1_year_r  <= sel.year;
    t1_month_r <= sel.month;
    t1_day_r   <= sel.day;
    t1_z_r     <= sel.z;
    t1_wx_r    <= wx_nxt;
    t1_pw_r    <= pw_nxt;
    t1_py_r    <= py_nxt;
    if (good) begin
      out_ok_r    <= 1'b1;
      out_count_r <= t1_mode_r ? '0 : $signed(cnt);
      out_year_r  <= t1_mode_r ? t1_year_r : '0;
      out_month_r <= t1_mode_r ? t1_month_r : '0;
      out_day_r   <= t1_mode_r ? t1_day_r : '0;
      out_wday_r  <= wrem[WDAY_W-1:0];
      out_leap_r  <= leap;
      out_mlen_r  <= mlen;
    end else begin
      out_ok_r    <= 1'b0;
      out_count_r <= '0;
      out_year_r  <= '0;
      out_month_r <= '0;
      out_day_r   <= '0;
      out_wday_r  <= '0;
      out_leap_r  <= 1'b0;
      out_mlen_r  <= '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_count_out    = out_count_r;
  assign out_year_out     = out_year_r;
  assign out_month_out    = out_month_r;
  assign out_day_out      = out_day_r;
  assign out_weekday      = out_wday_r;
  assign out_leap         = out_leap_r;
  assign out_month_length = out_mlen_r;

  // weekday remainder stays below seven
  a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_wday_r <= 3'd6)
    else $error("weekday out of range");

  // a converted count gives a day that exists in its month
  a_inv_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ok_r && (out_year_r != '0) |->
      (out_day_r != '0) && (out_day_r <= out_mlen_r))
    else $error("converted day outside its month");

  // a converted count gives a year and month in range
  a_inv_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ok_r && (out_year_r != '0) |->
      (out_year_r <= YEAR_MAX) && (out_month_r != '0) && (out_month_r <= MONTH_MAX))
    else $error("converted year or month out of range");

  // a converted date gives a count in the supported span
  a_fwd_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ok_r && (out_year_r == '0) |->
      (out_count_r >= -23'sd719162) && (out_count_r <= 23'sd2932896))
    else $error("day count out of span");

endmodule

### rtl/civil_date_day_count_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_date_day_count_converter: proleptic gregorian date <-> day count
// Converts a civil date to days since 1970-01-01, or a day count back to a
// civil date, with weekday, leap flag and month length.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: raise start with in_mode and the fields; it is taken at any
//   edge where start is high and busy is low. busy is high only while rst_n
//   is low, so a beat may be given in every cycle, either mode, in any mix.
//   in_mode 0 reads in_year_in/in_month_in/in_day_in, in_mode 1 reads
//   in_count_in; the other fields are ignored.
//   Result beat: out_valid is high for one cycle per input beat, in input
//   order. A beat goes through its lane and then the two shared stages before
//   it shows on the out_ ports; one result per cycle sustained.
//   The depth is set by the count-to-date lane, nine stages doing constant
//   divisions by reciprocal, plus two shared stages for weekday, leap rule and
//   checks; dates go through a shorter lane padded to the same depth.
//   A bad date or a count outside 0001-01-01..9999-12-31 returns out_ok low
//   with every other field zero.
//   Reset (rst_n low, synchronous) drops every beat in flight; no result
//   follows for beats taken before it. The receiver cannot stall the block:
//   each result must be taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module civil_date_day_count_converter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_mode,
  input  logic [dcv_pkg::YEAR_W-1:0]             in_year_in,
  input  logic [dcv_pkg::MONTH_W-1:0]            in_month_in,
  input  logic [dcv_pkg::DAY_W-1:0]              in_day_in,
  input  logic signed [dcv_pkg::COUNT_IN_W-1:0]  in_count_in,
  output logic                                   out_valid,
  output logic                                   out_ok,
  output logic signed [dcv_pkg::COUNT_OUT_W-1:0] out_count_out,
  output logic [dcv_pkg::YEAR_W-1:0]             out_year_out,
  output logic [dcv_pkg::MONTH_W-1:0]            out_month_out,
  output logic [dcv_pkg::DAY_W-1:0]              out_day_out,
  output logic [dcv_pkg::WDAY_W-1:0]             out_weekday,
  output logic                                   out_leap,
  output logic [dcv_pkg::DAY_W-1:0]              out_month_length
);
  import dcv_pkg::*;

  logic  accept;
  lane_t fwd_lane, inv_lane;

  // fully pipelined, a beat is taken whenever offered outside reset
  assign busy   = !rst_n;
  assign accept = start && !busy;

  // date to count lane
  dcv_fwd u_fwd (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (accept && !in_mode),
    .year   (in_year_in),
    .month  (in_month_in),
    .day    (in_day_in),
    .lane   (fwd_lane)
  );

  // count to date lane
  dcv_inv u_inv (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (accept && in_mode),
    .count  (in_count_in),
    .lane   (inv_lane)
  );

  // shared result stages
  dcv_tail u_tail (
    .clk              (clk),
    .rst_n            (rst_n),
    .fwd              (fwd_lane),
    .inv              (inv_lane),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_count_out    (out_count_out),
    .out_year_out     (out_year_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .out_weekday      (out_weekday),
    .out_leap         (out_leap),
    .out_month_length (out_month_length)
  );

endmodule

### bench/civil_date_day_count_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_date_day_count_converter_tb: self-checking bench for the date converter
// Drives civil dates and day counts through the command port. Each accepted
// beat is run through a behavioral calendar model kept in the bench. Every
// result beat is compared field by field against the oldest expectation.
// Directed edge cases come first, then random dates, random counts and a
// back-to-back tail. Random gaps are placed on the input side.
// ----------------------------------------------------------------------------
module civil_date_day_count_converter_tb;
  import dcv_pkg::*;

  // conversion direction
  localparam logic MODE_TO_COUNT = 1'b0;
  localparam logic MODE_TO_DATE  = 1'b1;

  // calendar span and method constants
  localparam longint FIRST_COUNT  = -719162;   // 0001-01-01
  localparam longint LAST_COUNT   = 2932896;   // 9999-12-31
  localparam longint EPOCH_OFFSET = 719468;    // 0000-03-01 to 1970-01-01
  localparam longint DAYS_PER_ERA = 146097;
  localparam longint YEARS_PER_ERA = 400;
  localparam longint LAST_YEAR    = 9999;
  localparam longint LAST_MONTH   = 12;

  localparam int RESULT_LATENCY = 11;
  localparam int STALL_LIMIT    = 1000;

  typedef struct packed {
    logic                          ok;
    logic signed [COUNT_OUT_W-1:0] count;
    logic [YEAR_W-1:0]             year;
    logic [MONTH_W-1:0]            month;
    logic [DAY_W-1:0]              day;
    logic [WDAY_W-1:0]             wday;
    logic                          leap;
    logic [DAY_W-1:0]              mlen;
  } conv_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_mode = 1'b0;
  logic [YEAR_W-1:0]             in_year_in = '0;
  logic [MONTH_W-1:0]            in_month_in = '0;
  logic [DAY_W-1:0]              in_day_in = '0;
  logic signed [COUNT_IN_W-1:0]  in_count_in = '0;
  logic                          out_valid;
  logic                          out_ok;
  logic signed [COUNT_OUT_W-1:0] out_count_out;
  logic [YEAR_W-1:0]             out_year_out;
  logic [MONTH_W-1:0]            out_month_out;
  logic [DAY_W-1:0]              out_day_out;
  logic [WDAY_W-1:0]             out_weekday;
  logic                          out_leap;
  logic [DAY_W-1:0]              out_month_length;

  conv_result_t pending_results[$];
  int           error_count = 0;
  int           gap_pct = 0;
  int           quiet_cycles = 0;

  civil_date_day_count_converter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_year_in       (in_year_in),
    .in_month_in      (in_month_in),
    .in_day_in        (in_day_in),
    .in_count_in      (in_count_in),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_count_out    (out_count_out),
    .out_year_out     (out_year_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .out_weekday      (out_weekday),
    .out_leap         (out_leap),
    .out_month_length (out_month_length)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gregorian leap rule
  function automatic bit is_gregorian_leap(input longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int days_in_month(input longint y, input longint m);
    case (m)
      2:             return is_gregorian_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default:       return 0;
    endcase
  endfunction

  // expected result of one beat, era based civil-days method
  function automatic conv_result_t predict_conversion(
    input logic                         mode,
    input logic [YEAR_W-1:0]            y_in,
    input logic [MONTH_W-1:0]           m_in,
    input logic [DAY_W-1:0]             d_in,
    input logic signed [COUNT_IN_W-1:0] cnt_in
  );
    conv_result_t r;
    longint y, m, d, yy, era, yoe, doy, doe, days, z, mp;
    r = '0;
    if (mode == MODE_TO_COUNT) begin
      y = y_in;
      m = m_in;
      d = d_in;
      if (y < 1 || y > LAST_YEAR || m < 1 || m > LAST_MONTH) return r;
      if (d < 1 || d > days_in_month(y, m)) return r;
      // march-based year so the leap day falls at the end
      yy   = y - ((m <= 2) ? 1 : 0);
      era  = yy / YEARS_PER_ERA;
      yoe  = yy - era * YEARS_PER_ERA;
      doy  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * DAYS_PER_ERA + doe - EPOCH_OFFSET;
      r.count = COUNT_OUT_W'(days);
    end else begin
      days = cnt_in;
      if (days < FIRST_COUNT || days > LAST_COUNT) return r;
      z   = days + EPOCH_OFFSET;
      era = z / DAYS_PER_ERA;
      doe = z - era * DAYS_PER_ERA;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      y   = yoe + era * YEARS_PER_ERA;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      d   = doy - (153 * mp + 2) / 5 + 1;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      if (m <= 2) y = y + 1;
      r.year  = YEAR_W'(y);
      r.month = MONTH_W'(m);
      r.day   = DAY_W'(d);
    end
    r.ok   = 1'b1;
    r.wday = WDAY_W'((days - FIRST_COUNT) % 7);
    r.leap = is_gregorian_leap(y);
    r.mlen = DAY_W'(days_in_month(y, m));
    return r;
  endfunction

  // drive one beat and hold it until taken
  task automatic send_beat(input logic mode, input logic [YEAR_W-1:0] y,
                           input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
                           input logic signed [COUNT_IN_W-1:0] cnt);
    start       <= 1'b1;
    in_mode     <= mode;
    in_year_in  <= y;
    in_month_in <= m;
    in_day_in   <= d;
    in_count_in <= cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_conversion(mode, y, m, d, cnt));
  endtask

  // random idle burst on the input side
  task automatic gap_inputs();
    int n;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_date(input int y, input int m, input int d);
    send_beat(MODE_TO_COUNT, YEAR_W'(y), MONTH_W'(m), DAY_W'(d), COUNT_IN_W'($urandom));
    gap_inputs();
  endtask

  task automatic send_count(input longint cnt);
    send_beat(MODE_TO_DATE, YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
              COUNT_IN_W'(cnt));
    gap_inputs();
  endtask

  task automatic pick_valid_date(output int y, output int m, output int d);
    y = $urandom_range(1, LAST_YEAR);
    m = $urandom_range(1, LAST_MONTH);
    // favor the last day of the month now and then
    if ($urandom_range(0, 4) == 0) d = days_in_month(y, m);
    else d = $urandom_range(1, days_in_month(y, m));
  endtask

  // span ends, epoch, century leap rule, bad fields
  task automatic test_date_edges();
    gap_pct = 30;
    send_date(1, 1, 1);
    send_date(9999, 12, 31);
    send_date(1970, 1, 1);
    send_date(1969, 12, 31);
    send_date(2000, 2, 29);
    send_date(1900, 2, 29);
    send_date(1900, 2, 28);
    send_date(2023, 2, 29);
    send_date(0, 6, 15);
    send_date(10000, 1, 1);
    send_date(16383, 15, 31);
    send_date(2024, 0, 10);
    send_date(2024, 13, 10);
    send_date(2024, 4, 0);
    send_date(2024, 4, 31);
  endtask

  // span ends and just outside, epoch, extremes of the 24-bit count
  task automatic test_count_edges();
    gap_pct = 30;
    send_count(FIRST_COUNT);
    send_count(LAST_COUNT);
    send_count(FIRST_COUNT - 1);
    send_count(LAST_COUNT + 1);
    send_count(0);
    send_count(-1);
    send_count(11016);
    send_count(-8388608);
    send_count(8388607);
  endtask

  // mostly well-formed dates, some near the limits, some raw noise
  task automatic test_random_dates(input int n);
    int y, m, d, r;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) gap_pct = $urandom_range(0, 1) ? 0 : 25;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        pick_valid_date(y, m, d);
      end else if (r < 90) begin
        case ($urandom_range(0, 4))
          0:       y = 1;
          1:       y = LAST_YEAR;
          2:       y = 100 * $urandom_range(1, 99);
          3:       y = 1969 + $urandom_range(0, 1);
          default: y = LAST_YEAR + 1;
        endcase
        m = $urandom_range(1, LAST_MONTH);
        d = days_in_month(y, m) + $urandom_range(0, 1);
      end else begin
        y = $urandom_range(0, (1 << YEAR_W) - 1);
        m = $urandom_range(0, (1 << MONTH_W) - 1);
        d = $urandom_range(0, (1 << DAY_W) - 1);
      end
      send_date(y, m, d);
    end
  endtask

  // mostly in-span counts, some at the span ends, some full-width noise
  task automatic test_random_counts(input int n);
    longint cnt;
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) gap_pct = $urandom_range(0, 1) ? 0 : 25;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        cnt = FIRST_COUNT + longint'($urandom_range(0, LAST_COUNT - FIRST_COUNT));
      end else if (r < 85) begin
        case ($urandom_range(0, 2))
          0:       cnt = FIRST_COUNT;
          1:       cnt = LAST_COUNT;
          default: cnt = 0;
        endcase
        cnt = cnt + $urandom_range(0, 6) - 3;
      end else begin
        cnt = longint'($signed(COUNT_IN_W'($urandom)));
      end
      send_count(cnt);
    end
  endtask

  // back-to-back beats of mixed modes, no gaps
  task automatic test_back_to_back(input int n);
    int y, m, d;
    gap_pct = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) begin
        pick_valid_date(y, m, d);
        send_date(y, m, d);
      end else begin
        send_count(FIRST_COUNT + longint'($urandom_range(0, LAST_COUNT - FIRST_COUNT)));
      end
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    conv_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("ok", want.ok, out_ok);
        check_field("count_out", want.count, out_count_out);
        check_field("year_out", want.year, out_year_out);
        check_field("month_out", want.month, out_month_out);
        check_field("day_out", want.day, out_day_out);
        check_field("weekday", want.wday, out_weekday);
        check_field("leap", want.leap, out_leap);
        check_field("month_length", want.mlen, out_month_length);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL civil_date_day_count_converter");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_date_edges();
    test_count_edges();
    test_random_dates(900);
    test_random_counts(900);
    test_back_to_back(50);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * RESULT_LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS civil_date_day_count_converter");
    end else begin
      $display("FAIL civil_date_day_count_converter");
    end
    $finish;
  end

endmodule
